>>> rtl/rlid_pkg.sv
package rlid_pkg;

  localparam int MAX_LISTS = 16;
  localparam int MAX_DEPTH = 256;
  localparam int MAX_OUT   = 256;

  localparam int DOC_W   = 32;
  localparam int KIND_W  = 2;
  localparam int LIDX_W  = 4;
  localparam int TOP_W   = 9;
  localparam int LIST_W  = $clog2(MAX_LISTS);
  localparam int DEPTH_W = $clog2(MAX_DEPTH);
  localparam int LEN_W   = $clog2(MAX_DEPTH + 1);
  localparam int LCNT_W  = $clog2(MAX_LISTS + 1);
  localparam int OUT_W   = $clog2(MAX_OUT);
  localparam int OCNT_W  = $clog2(MAX_OUT + 1);
  localparam int LADDR_W = LIST_W + DEPTH_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_ADDR_W-3:0] REG_OUT_LIMIT = 1'b0;
  localparam logic [TOP_W-1:0]      TOP_RESET     = 9'd256;

endpackage

>>> rtl/rlid_if.sv
interface rlid_in_if import rlid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LIDX_W-1:0] list_index;
  logic [DOC_W-1:0]  doc_id;

  modport source (output valid, kind, list_index, doc_id, input ready);
  modport sink (input valid, kind, list_index, doc_id, output ready);
endinterface

interface rlid_out_if import rlid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DOC_W-1:0] result_doc;
  logic [TOP_W-1:0] rank;
  logic [TOP_W-1:0] pseudo_score;
  logic             valid_res;
  logic             last;

  modport source (output valid, result_doc, rank, pseudo_score, valid_res, last,
                  input ready);
  modport sink (input valid, result_doc, rank, pseudo_score, valid_res, last,
                output ready);
endinterface

>>> rtl/rlid_ram.sv
module rlid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> rtl/ranked_list_interleave_dedup.sv
// Channel   Direction  Payload                                           Handshake
// in_ch     sink       kind, list_index, doc_id                          valid/ready
// out_ch    source     result_doc, rank, pseudo_score, valid_res, last   valid/ready
// cfg_*     slave      result limit at byte address 0                    APB, pready high
//
// Load, clear and ignored transactions complete in the idle state. A next transaction is accepted,
// scans list positions, depth changes and the end check, reads each candidate from the list memory,
// compares it with every seen entry and, if new, records it; a found result below the limit rescans
// from the new cursor to decide last, and the result is then loaded into the output register.
// Reset is synchronous and active low; the list and seen memories are not cleared.
// The input is held off while the sequencer is busy or a result waits for the output register.
module ranked_list_interleave_dedup import rlid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rlid_in_if.sink               in_ch,
  rlid_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LRD  = 3'd2;
  localparam logic [2:0] S_SEEN = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [TOP_W-1:0]  top_r;
  logic [LEN_W-1:0]  len_r [MAX_LISTS];
  logic [LEN_W-1:0]  len_nxt [MAX_LISTS];
  logic [LCNT_W-1:0] lcnt_r, lcnt_nxt;
  logic [LEN_W-1:0]  deep_r, deep_nxt;
  logic [OCNT_W-1:0] emit_r, emit_nxt;
  logic [LEN_W-1:0]  cur_d_r, cur_d_nxt;
  logic [LIST_W-1:0] cur_l_r, cur_l_nxt;
  logic [LEN_W-1:0]  d_r, d_nxt;
  logic [LCNT_W-1:0] l_r, l_nxt;
  logic [OCNT_W-1:0] idx_r, idx_nxt;
  logic              look_r, look_nxt;
  logic [DOC_W-1:0]  cand_r, cand_nxt;
  logic [DOC_W-1:0]  res_doc_r, res_doc_nxt;
  logic [TOP_W-1:0]  res_rank_r, res_rank_nxt;
  logic [TOP_W-1:0]  res_score_r, res_score_nxt;
  logic              res_vld_r, res_vld_nxt;
  logic              res_last_r, res_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DOC_W-1:0]  out_doc_r, out_doc_nxt;
  logic [TOP_W-1:0]  out_rank_r, out_rank_nxt;
  logic [TOP_W-1:0]  out_score_r, out_score_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_last_r, out_last_nxt;

  logic               in_fire;
  logic               cfg_wr;
  logic [OCNT_W-1:0]  limit;
  logic [LIST_W-1:0]  ld_list;
  logic [LEN_W-1:0]   ld_len;
  logic [LCNT_W-1:0]  l_inc;
  logic [OCNT_W-1:0]  emit_inc;
  logic               lst_we;
  logic [LADDR_W-1:0] lst_waddr;
  logic               lst_re;
  logic [LADDR_W-1:0] lst_raddr;
  logic [DOC_W-1:0]   lst_rdata;
  logic               seen_we;
  logic               seen_re;
  logic [DOC_W-1:0]   seen_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata  = (cfg_paddr[CFG_ADDR_W-1:2] == REG_OUT_LIMIT) ?
                       CFG_DATA_W'(top_r) : '0;

  assign limit    = (top_r < TOP_W'(MAX_OUT)) ? OCNT_W'(top_r) : OCNT_W'(MAX_OUT);
  assign ld_list  = in_ch.list_index[LIST_W-1:0];
  assign ld_len   = len_r[ld_list];
  assign l_inc    = l_r + 1'b1;
  assign emit_inc = emit_r + 1'b1;

  assign lst_we    = in_fire && (in_ch.kind == KIND_LOAD) && (ld_len < LEN_W'(MAX_DEPTH));
  assign lst_waddr = {ld_list, ld_len[DEPTH_W-1:0]};
  assign lst_raddr = {l_r[LIST_W-1:0], d_r[DEPTH_W-1:0]};
  assign lst_re    = (state_r == S_SCAN) && (d_r < deep_r) && (l_r < lcnt_r) &&
                     (d_r < len_r[l_r[LIST_W-1:0]]);
  assign seen_re   = (state_r == S_SEEN) && (idx_r < emit_r);
  assign seen_we   = (state_r == S_SEEN) && (idx_r >= emit_r) && !look_r;

  rlid_ram #(.WIDTH(DOC_W), .DEPTH(MAX_LISTS * MAX_DEPTH)) u_list_ram (
    .clk     (clk),
    .wr_en   (lst_we),
    .wr_addr (lst_waddr),
    .wr_data (in_ch.doc_id),
    .rd_en   (lst_re),
    .rd_addr (lst_raddr),
    .rd_data (lst_rdata)
  );

  rlid_ram #(.WIDTH(DOC_W), .DEPTH(MAX_OUT)) u_seen_ram (
    .clk     (clk),
    .wr_en   (seen_we),
    .wr_addr (emit_r[OUT_W-1:0]),
    .wr_data (cand_r),
    .rd_en   (seen_re),
    .rd_addr (idx_r[OUT_W-1:0]),
    .rd_data (seen_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    lcnt_nxt      = lcnt_r;
    deep_nxt      = deep_r;
    emit_nxt      = emit_r;
    cur_d_nxt     = cur_d_r;
    cur_l_nxt     = cur_l_r;
    d_nxt         = d_r;
    l_nxt         = l_r;
    idx_nxt       = idx_r;
    look_nxt      = look_r;
    cand_nxt      = cand_r;
    res_doc_nxt   = res_doc_r;
    res_rank_nxt  = res_rank_r;
    res_score_nxt = res_score_r;
    res_vld_nxt   = res_vld_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_doc_nxt   = out_doc_r;
    out_rank_nxt  = out_rank_r;
    out_score_nxt = out_score_r;
    out_vld_nxt   = out_vld_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.kind)
            KIND_LOAD: begin
              if (lst_we) begin
                len_nxt[ld_list] = ld_len + 1'b1;
                if (ld_len + 1'b1 > deep_r) begin
                  deep_nxt = ld_len + 1'b1;
                end
                if (LCNT_W'(ld_list) + 1'b1 > lcnt_r) begin
                  lcnt_nxt = LCNT_W'(ld_list) + 1'b1;
                end
              end
            end
            KIND_CLEAR: begin
              for (int i = 0; i < MAX_LISTS; i++) begin
                len_nxt[i] = '0;
              end
              lcnt_nxt  = '0;
              deep_nxt  = '0;
              emit_nxt  = '0;
              cur_d_nxt = '0;
              cur_l_nxt = '0;
            end
            KIND_NEXT: begin
              look_nxt = 1'b0;
              d_nxt    = cur_d_r;
              l_nxt    = LCNT_W'(cur_l_r);
              if (emit_r >= limit) begin
                res_doc_nxt   = '0;
                res_rank_nxt  = '0;
                res_score_nxt = '0;
                res_vld_nxt   = 1'b0;
                res_last_nxt  = 1'b1;
                state_nxt     = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (d_r >= deep_r) begin
          if (!look_r) begin
            res_doc_nxt   = '0;
            res_rank_nxt  = '0;
            res_score_nxt = '0;
            res_vld_nxt   = 1'b0;
          end
          res_last_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else if (l_r >= lcnt_r) begin
          l_nxt = '0;
          d_nxt = d_r + 1'b1;
        end else if (lst_re) begin
          state_nxt = S_LRD;
        end else begin
          l_nxt = l_inc;
        end
      end
      S_LRD: begin
        cand_nxt  = lst_rdata;
        idx_nxt   = '0;
        state_nxt = S_SEEN;
      end
      S_SEEN: begin
        if (idx_r < emit_r) begin
          state_nxt = S_SRD;
        end else if (look_r) begin
          res_last_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end else begin
          res_doc_nxt   = cand_r;
          res_rank_nxt  = TOP_W'(emit_inc);
          res_score_nxt = top_r - TOP_W'(emit_r);
          res_vld_nxt   = 1'b1;
          emit_nxt      = emit_inc;
          if (l_inc >= lcnt_r) begin
            l_nxt     = '0;
            d_nxt     = d_r + 1'b1;
            cur_l_nxt = '0;
            cur_d_nxt = d_r + 1'b1;
          end else begin
            l_nxt     = l_inc;
            cur_l_nxt = l_inc[LIST_W-1:0];
            cur_d_nxt = d_r;
          end
          if (emit_inc < limit) begin
            look_nxt  = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            res_last_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_SRD: begin
        if (seen_rdata == cand_r) begin
          l_nxt     = l_inc;
          state_nxt = S_SCAN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SEEN;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_doc_nxt   = res_doc_r;
          out_rank_nxt  = res_rank_r;
          out_score_nxt = res_score_r;
          out_vld_nxt   = res_vld_r;
          out_last_nxt  = res_last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= TOP_RESET;
      for (int i = 0; i < MAX_LISTS; i++) begin
        len_r[i] <= '0;
      end
      lcnt_r      <= '0;
      deep_r      <= '0;
      emit_r      <= '0;
      cur_d_r     <= '0;
      cur_l_r     <= '0;
      out_valid_r <= 1'b0;
      look_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_OUT_LIMIT)) begin
        top_r <= cfg_pwdata[TOP_W-1:0];
      end
      len_r       <= len_nxt;
      lcnt_r      <= lcnt_nxt;
      deep_r      <= deep_nxt;
      emit_r      <= emit_nxt;
      cur_d_r     <= cur_d_nxt;
      cur_l_r     <= cur_l_nxt;
      out_valid_r <= out_valid_nxt;
      look_r      <= look_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    l_r         <= l_nxt;
    idx_r       <= idx_nxt;
    cand_r      <= cand_nxt;
    res_doc_r   <= res_doc_nxt;
    res_rank_r  <= res_rank_nxt;
    res_score_r <= res_score_nxt;
    res_vld_r   <= res_vld_nxt;
    res_last_r  <= res_last_nxt;
    out_doc_r   <= out_doc_nxt;
    out_rank_r  <= out_rank_nxt;
    out_score_r <= out_score_nxt;
    out_vld_r   <= out_vld_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_doc   = out_doc_r;
  assign out_ch.rank         = out_rank_r;
  assign out_ch.pseudo_score = out_score_r;
  assign out_ch.valid_res    = out_vld_r;
  assign out_ch.last         = out_last_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.last)
    else $error("Result without a document is not flagged last.");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (LCNT_W'(cur_l_r) < lcnt_r) || (cur_l_r == '0))
    else $error("Cursor points past the loaded lists.");

  a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= OCNT_W'(MAX_OUT))
    else $error("Emitted count exceeds the seen memory depth.");

  a_main_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_r != S_EMIT) && !look_r |-> emit_r < limit)
    else $error("Search for a result started at the output limit.");

endmodule

>>> sim/ranked_list_interleave_dedup_checker.sv
`timescale 1ns / 1ps

module ranked_list_interleave_dedup_checker import rlid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rlid_in_if                    in_mon,
  rlid_out_if                   out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    errors,
  output int                    pending
);

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [DOC_W-1:0] doc;
    logic [TOP_W-1:0] rank;
    logic [TOP_W-1:0] score;
    logic             valid_res;
    logic             last;
  } fused_t;

  logic [DOC_W-1:0]  lists [MAX_LISTS][MAX_DEPTH];
  logic [LEN_W-1:0]  list_len [MAX_LISTS];
  logic [LCNT_W-1:0] lists_used;
  logic [DOC_W-1:0]  emitted_docs [MAX_OUT];
  logic [OCNT_W-1:0] emitted;
  logic [LEN_W-1:0]  cur_depth;
  logic [LIST_W-1:0] cur_list;
  logic [TOP_W-1:0]  out_limit;
  fused_t            fused_q [$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  function automatic void clear_walk();
    for (int i = 0; i < MAX_LISTS; i++) begin
      list_len[i] = '0;
    end
    lists_used = '0;
    emitted    = '0;
    cur_depth  = '0;
    cur_list   = '0;
  endfunction

  function automatic bit already_emitted(input logic [DOC_W-1:0] doc);
    for (int i = 0; i < emitted && i < MAX_OUT; i++) begin
      if (emitted_docs[i] == doc) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned deepest_len();
    int unsigned m;
    m = 0;
    for (int i = 0; i < lists_used && i < MAX_LISTS; i++) begin
      if (list_len[i] > m) m = list_len[i];
    end
    return m;
  endfunction

  // Walks depth by depth from (d, l) and stops on the first id not yet emitted.
  function automatic bit scan_unseen(inout int unsigned d, inout int unsigned l,
                                     output logic [DOC_W-1:0] doc);
    int unsigned deep;
    deep = deepest_len();
    doc  = '0;
    while (d < deep) begin
      if (l >= lists_used || l >= MAX_LISTS) begin
        l = 0;
        d++;
      end else begin
        if (d < list_len[l] && !already_emitted(lists[l][d])) begin
          doc = lists[l][d];
          return 1'b1;
        end
        l++;
      end
    end
    return 1'b0;
  endfunction

  function automatic fused_t predict_next();
    fused_t           r;
    int unsigned      cap;
    int unsigned      d;
    int unsigned      l;
    int unsigned      k;
    int unsigned      d2;
    int unsigned      l2;
    logic [DOC_W-1:0] doc;
    logic [DOC_W-1:0] doc2;
    r      = '0;
    r.last = 1'b1;
    cap    = (out_limit < MAX_OUT) ? out_limit : MAX_OUT;
    d      = cur_depth;
    l      = cur_list;
    if (emitted >= cap || !scan_unseen(d, l, doc)) return r;
    k               = emitted;
    emitted_docs[k] = doc;
    emitted         = OCNT_W'(k + 1);
    l++;
    if (l >= lists_used) begin
      l = 0;
      d++;
    end
    cur_depth   = LEN_W'(d);
    cur_list    = LIST_W'(l);
    r.doc       = doc;
    r.rank      = TOP_W'(k + 1);
    r.score     = TOP_W'(out_limit - k);
    r.valid_res = 1'b1;
    d2          = d;
    l2          = l;
    r.last      = !(emitted < cap && scan_unseen(d2, l2, doc2));
    return r;
  endfunction

  always @(posedge clk) begin
    fused_t      want;
    int unsigned li;
    if (!rst_n) begin
      clear_walk();
      out_limit = TOP_RESET;
      fused_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_OUT_LIMIT, 2'b00}) begin
        out_limit = cfg_pwdata[TOP_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        li = in_mon.list_index;
        case (in_mon.kind)
          KIND_LOAD: begin
            if (li < MAX_LISTS && list_len[li] < MAX_DEPTH) begin
              lists[li][list_len[li]] = in_mon.doc_id;
              list_len[li]            = list_len[li] + 1'b1;
              if (li + 1 > lists_used) lists_used = LCNT_W'(li + 1);
            end
          end
          KIND_NEXT: begin
            fused_q.push_back(predict_next());
          end
          KIND_CLEAR: begin
            clear_walk();
          end
          default: begin
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (fused_q.size() == 0) begin
          flag_mismatch("result with no next pending", out_mon.result_doc, '0);
        end else begin
          want = fused_q.pop_front();
          if (out_mon.result_doc !== want.doc) begin
            flag_mismatch("result_doc", out_mon.result_doc, want.doc);
          end
          if (out_mon.rank !== want.rank) begin
            flag_mismatch("rank", out_mon.rank, want.rank);
          end
          if (out_mon.pseudo_score !== want.score) begin
            flag_mismatch("pseudo_score", out_mon.pseudo_score, want.score);
          end
          if (out_mon.valid_res !== want.valid_res) begin
            flag_mismatch("valid_res", out_mon.valid_res, want.valid_res);
          end
          if (out_mon.last !== want.last) begin
            flag_mismatch("last", out_mon.last, want.last);
          end
        end
      end
    end
    pending <= fused_q.size();
  end

endmodule

>>> sim/ranked_list_interleave_dedup_tb.sv
`timescale 1ns / 1ps

module ranked_list_interleave_dedup_tb;
  import rlid_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int GAP_PCT       = 28;
  localparam int TOTAL_ITEMS   = 900;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    errors;
  int                    pending;
  int                    sent;
  int                    hold_seq;
  bit                    jitter;

  rlid_in_if  in_ch ();
  rlid_out_if out_ch ();

  ranked_list_interleave_dedup i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ranked_list_interleave_dedup_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [LIDX_W-1:0] list_index,
                           input logic [DOC_W-1:0] doc_id);
    while (jitter && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.list_index <= list_index;
    in_ch.doc_id     <= doc_id;
    do @(posedge clk); while (!in_ch.ready);
    if (kind != KIND_UNUSED) sent++;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_out_limit(input logic [TOP_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_OUT_LIMIT, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [TOP_W-1:0] pick_top();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TOP_W'(1);
      2:       return TOP_W'(MAX_OUT);
      3:       return '1;
      4:       return TOP_W'(MAX_OUT - 1);
      5:       return TOP_W'($urandom_range(511));
      default: return TOP_W'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [LIDX_W-1:0] pick_list(input int unsigned n_lists);
    if ($urandom_range(9) == 0) return LIDX_W'($urandom_range(15));
    return LIDX_W'($urandom_range(n_lists - 1));
  endfunction

  function automatic logic [DOC_W-1:0] pick_doc(input logic [DOC_W-1:0] base,
                                                input int unsigned span);
    if ($urandom_range(6) == 0) return $urandom;
    return base + $urandom_range(span - 1);
  endfunction

  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !jitter || $urandom_range(99) >= GAP_PCT;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned      n_lists;
    int unsigned      span;
    int unsigned      roll;
    int               query;
    logic [DOC_W-1:0] base;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.list_index = '0;
    in_ch.doc_id     = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    jitter           = 1'b1;
    hold_seq         = 0;
    sent             = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_UNUSED, 4'd15, '1);
    send_item(KIND_LOAD, 4'd0, 32'h0000_0000);
    send_item(KIND_LOAD, 4'd0, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 4'd15, 32'h5A5A_A5A5);
    send_item(KIND_LOAD, 4'd1, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 4'd1, 32'hA5A5_5A5A);
    send_item(KIND_LOAD, 4'd15, 32'h0000_0000);
    repeat (5) send_item(KIND_NEXT, '0, '0);
    send_item(KIND_LOAD, 4'd3, 32'd9);
    send_item(KIND_LOAD, 4'd3, 32'd11);
    repeat (2) send_item(KIND_NEXT, '0, '0);
    send_item(KIND_CLEAR, '0, '0);
    send_item(KIND_NEXT, '0, '0);
    quiesce();
    write_out_limit('0);
    send_item(KIND_LOAD, 4'd0, 32'd1);
    send_item(KIND_NEXT, '0, '0);
    quiesce();
    write_out_limit(TOP_W'(2));
    send_item(KIND_NEXT, '0, '0);
    send_item(KIND_LOAD, 4'd0, 32'd2);
    send_item(KIND_LOAD, 4'd0, 32'd3);
    repeat (2) send_item(KIND_NEXT, '0, '0);
    send_item(KIND_CLEAR, '0, '0);

    // One list filled past its depth with distinct ids, then walked to the output limit.
    quiesce();
    write_out_limit('1);
    jitter = 1'b0;
    for (int i = 0; i <= MAX_DEPTH; i++) begin
      send_item(KIND_LOAD, LIDX_W'(MAX_LISTS - 1), DOC_W'(i) * 32'h9E37_79B9 + 32'h1234_5677);
    end
    repeat (MAX_OUT + 1) send_item(KIND_NEXT, '0, '0);
    send_item(KIND_CLEAR, '0, '0);
    jitter = 1'b1;

    query = 0;
    while (sent < TOTAL_ITEMS) begin
      n_lists = $urandom_range(4, 1);
      span    = $urandom_range(24, 2);
      base    = $urandom;
      if ($urandom_range(2) == 0) begin
        quiesce();
        write_out_limit(pick_top());
      end
      if (query == 3) hold_seq++;
      repeat ($urandom_range(20)) send_item(KIND_LOAD, pick_list(n_lists), pick_doc(base, span));
      repeat ($urandom_range(40, 10)) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          quiesce();
          write_out_limit(TOP_W'($urandom_range(4)));
        end else if (roll < 65) begin
          send_item(KIND_NEXT, LIDX_W'($urandom_range(15)), $urandom);
        end else if (roll < 85) begin
          send_item(KIND_LOAD, pick_list(n_lists), pick_doc(base, span));
        end else if (roll < 90) begin
          send_item(KIND_LOAD, LIDX_W'($urandom_range(15)), $urandom);
        end else if (roll < 95) begin
          send_item(KIND_UNUSED, LIDX_W'($urandom_range(15)), $urandom);
        end else begin
          send_item(KIND_NEXT, '0, '0);
        end
      end
      if ($urandom_range(9) != 0) begin
        send_item(KIND_CLEAR, LIDX_W'($urandom_range(15)), $urandom);
      end
      query++;
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
